// ===== design/hdm_pkg.sv =====
// shared constants, types and angle helpers of the holonomic drive mixer
package hdm_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ANGLE_BITS    = 16;

	localparam int STICK_W   = 8;
	localparam int HEADING_W = 16;
	localparam int WHEEL_W   = 10;
	localparam int MODE_W    = 2;

	localparam logic [MODE_W-1:0] MODE_FIELD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ROBOT = 2'd1;

	localparam int SQ_W        = 2 * STICK_W;
	localparam int ISQRT_STEPS = SQ_W / 2;
	localparam int ROOT_W      = SQ_W + 1;
	localparam int MAG_W       = STICK_W;

	localparam int VEC_SHIFT = 24;
	localparam int VEC_W     = STICK_W + VEC_SHIFT + 4;

	localparam int GAIN_W  = 30;
	localparam int Q_SHIFT = 30;
	localparam logic [GAIN_W-1:0] GAIN_COMP_Q30 = 30'd652032874;
	localparam int ROT_W   = MAG_W + Q_SHIFT + 3;
	localparam int ZA_W    = ANGLE_BITS + 1;

	localparam logic [ANGLE_BITS-1:0] ANG_HALF    = ANGLE_BITS'(1 << (ANGLE_BITS - 1));
	localparam logic [ANGLE_BITS-1:0] ANG_QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

	localparam int ATAN_SH    = 32 - ANGLE_BITS;
	localparam int ATAN_DEPTH = 24;
	localparam logic [31:0] ATAN_TBL [ATAN_DEPTH] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20860,
		32'd10430,     32'd5215,      32'd2607,      32'd1303,
		32'd651,       32'd325,       32'd162,       32'd81
	};

	typedef struct packed {
		logic signed [STICK_W-1:0] rotate;
		logic [HEADING_W-1:0]      heading;
	} side_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic [ANGLE_BITS-1:0]   z;
		logic [ROOT_W-1:0]       rem;
		logic [ROOT_W-1:0]       root;
		side_t                   side;
	} vec_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle;
		logic [MAG_W-1:0]      mag;
		side_t                 side;
	} vec_out_t;

	typedef struct packed {
		logic signed [ROT_W-1:0]   x;
		logic signed [ROT_W-1:0]   y;
		logic signed [ZA_W-1:0]    a;
		logic                      neg;
		logic signed [STICK_W-1:0] rotate;
	} rot_t;

	typedef struct packed {
		logic signed [WHEEL_W-1:0] x;
		logic signed [WHEEL_W-1:0] y;
		logic signed [STICK_W-1:0] rotate;
	} rot_out_t;

	typedef struct packed {
		logic signed [WHEEL_W-1:0] d;
		logic signed [WHEEL_W-1:0] c;
		logic signed [WHEEL_W-1:0] b;
		logic signed [WHEEL_W-1:0] a;
	} wheels_t;

	function automatic logic [ANGLE_BITS-1:0] atan_units(input logic [4:0] idx);
		logic [32:0] t;
		t = {1'b0, ATAN_TBL[idx]} + (33'd1 << (ATAN_SH - 1));
		return t[ATAN_SH +: ANGLE_BITS];
	endfunction

	function automatic logic [ANGLE_BITS-1:0] align_heading(input logic [HEADING_W-1:0] h);
		logic [HEADING_W+ANGLE_BITS-1:0] t;
		t = {h, {ANGLE_BITS{1'b0}}};
		return t[HEADING_W+ANGLE_BITS-1 -: ANGLE_BITS];
	endfunction

endpackage

// ===== design/hdm_vectoring.sv =====
// vectoring cordic pipeline with a parallel integer square root for the stick magnitude
module hdm_vectoring import hdm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [STICK_W-1:0] in_x,
	input  logic signed [STICK_W-1:0] in_y,
	input  side_t                     in_side,
	output logic                      out_valid,
	output vec_out_t                  out_data
);

	vec_t                 vec_s [CORDIC_STAGES+1];
	logic [CORDIC_STAGES:0] vld_s;

	logic signed [STICK_W:0]     sx, sy, ax, ay;
	logic signed [2*STICK_W+1:0] sq_x, sq_y;
	logic [SQ_W-1:0]             sumsq;
	vec_t                        entry;

	always_comb begin
		sx = {in_x[STICK_W-1], in_x};
		sy = {in_y[STICK_W-1], in_y};
		sq_x = sx * sx;
		sq_y = sy * sy;
		sumsq = SQ_W'(sq_x + sq_y);
		entry.side = in_side;
		entry.rem = {{(ROOT_W-SQ_W){1'b0}}, sumsq};
		entry.root = '0;
		// left half plane starts at half a turn
		if (in_x[STICK_W-1]) begin
			ax = -sx;
			ay = -sy;
			entry.z = ANG_HALF;
		end else begin
			ax = sx;
			ay = sy;
			entry.z = '0;
		end
		entry.x = {{(VEC_W-STICK_W-1-VEC_SHIFT){ax[STICK_W]}}, ax, {VEC_SHIFT{1'b0}}};
		entry.y = {{(VEC_W-STICK_W-1-VEC_SHIFT){ay[STICK_W]}}, ay, {VEC_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s[0] <= entry;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic [ANGLE_BITS-1:0] ATAN_C = atan_units(5'(i));

		logic signed [VEC_W-1:0] cx, cy, xs, ys, nx, ny;
		logic [ANGLE_BITS-1:0]   nz;
		logic [ROOT_W-1:0]       nrem, nroot;

		always_comb begin
			cx = vec_s[i].x;
			cy = vec_s[i].y;
			xs = cx >>> i;
			ys = cy >>> i;
			if (cy[VEC_W-1]) begin
				nx = cx - ys;
				ny = cy + xs;
				nz = vec_s[i].z - ATAN_C;
			end else begin
				nx = cx + ys;
				ny = cy - xs;
				nz = vec_s[i].z + ATAN_C;
			end
		end

		if (i < ISQRT_STEPS) begin : g_sqrt
			localparam logic [ROOT_W-1:0] SQ_BIT = ROOT_W'(1) << (2 * (ISQRT_STEPS - 1 - i));

			logic [ROOT_W-1:0] trial;

			always_comb begin
				trial = vec_s[i].root + SQ_BIT;
				if (vec_s[i].rem >= trial) begin
					nrem = vec_s[i].rem - trial;
					nroot = (vec_s[i].root >> 1) + SQ_BIT;
				end else begin
					nrem = vec_s[i].rem;
					nroot = vec_s[i].root >> 1;
				end
			end
		end else begin : g_hold
			assign nrem = vec_s[i].rem;
			assign nroot = vec_s[i].root;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[i+1].x <= nx;
				vec_s[i+1].y <= ny;
				vec_s[i+1].z <= nz;
				vec_s[i+1].rem <= nrem;
				vec_s[i+1].root <= nroot;
				vec_s[i+1].side <= vec_s[i].side;
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STAGES];
	assign out_data.angle = vec_s[CORDIC_STAGES].z;
	assign out_data.mag = vec_s[CORDIC_STAGES].root[MAG_W-1:0];
	assign out_data.side = vec_s[CORDIC_STAGES].side;

endmodule

// ===== design/hdm_rotation.sv =====
// heading offset, rotation cordic pipeline and truncation back to stick units
module hdm_rotation import hdm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     heading_en,
	input  logic     in_valid,
	input  vec_out_t in_data,
	output logic     out_valid,
	output rot_out_t out_data
);

	localparam logic signed [ZA_W-1:0] A_QUARTER = ZA_W'(1 << (ANGLE_BITS - 2));
	localparam logic signed [ZA_W-1:0] A_HALF    = ZA_W'(1 << (ANGLE_BITS - 1));
	localparam logic signed [ROT_W-1:0] TRUNC_BIAS = ROT_W'((1 << Q_SHIFT) - 1);

	rot_t                   rot_s [CORDIC_STAGES+1];
	logic [CORDIC_STAGES:0] vld_s;

	logic [ANGLE_BITS-1:0]     hd, ang;
	logic signed [ZA_W-1:0]    sa;
	logic [MAG_W+GAIN_W-1:0]   prod;
	rot_t                      entry;

	always_comb begin
		hd = heading_en ? align_heading(in_data.side.heading) : '0;
		ang = in_data.angle + hd + ANG_QUARTER;
		sa = {ang[ANGLE_BITS-1], ang};
		prod = in_data.mag * GAIN_COMP_Q30;
		entry.x = {{(ROT_W-MAG_W-GAIN_W){1'b0}}, prod};
		entry.y = '0;
		entry.rotate = in_data.side.rotate;
		// fold angles beyond a quarter turn and negate at the end
		priority if (sa > A_QUARTER) begin
			entry.a = sa - A_HALF;
			entry.neg = 1'b1;
		end else if (sa < -A_QUARTER) begin
			entry.a = sa + A_HALF;
			entry.neg = 1'b1;
		end else begin
			entry.a = sa;
			entry.neg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s[0] <= entry;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [ZA_W-1:0] ATAN_Z = {1'b0, atan_units(5'(i))};

		logic signed [ROT_W-1:0] cx, cy, xs, ys, nx, ny;
		logic signed [ZA_W-1:0]  ca, na;

		always_comb begin
			cx = rot_s[i].x;
			cy = rot_s[i].y;
			ca = rot_s[i].a;
			xs = cx >>> i;
			ys = cy >>> i;
			if (!ca[ZA_W-1]) begin
				nx = cx - ys;
				ny = cy + xs;
				na = ca - ATAN_Z;
			end else begin
				nx = cx + ys;
				ny = cy - xs;
				na = ca + ATAN_Z;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rot_s[i+1].x <= nx;
				rot_s[i+1].y <= ny;
				rot_s[i+1].a <= na;
				rot_s[i+1].neg <= rot_s[i].neg;
				rot_s[i+1].rotate <= rot_s[i].rotate;
			end
		end
	end

	// divide by 2^30 toward zero, then undo the fold
	logic signed [ROT_W-1:0]   fx, fy, bx, by;
	logic signed [WHEEL_W-1:0] tx, ty;
	logic                      fin_v_s;
	rot_out_t                  fin_s;

	always_comb begin
		fx = rot_s[CORDIC_STAGES].x;
		fy = rot_s[CORDIC_STAGES].y;
		bx = (fx + (fx[ROT_W-1] ? TRUNC_BIAS : '0)) >>> Q_SHIFT;
		by = (fy + (fy[ROT_W-1] ? TRUNC_BIAS : '0)) >>> Q_SHIFT;
		tx = WHEEL_W'(bx);
		ty = WHEEL_W'(by);
		if (rot_s[CORDIC_STAGES].neg) begin
			tx = -tx;
			ty = -ty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s <= 1'b0;
		end else if (en) begin
			fin_v_s <= vld_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s.x <= tx;
			fin_s.y <= ty;
			fin_s.rotate <= rot_s[CORDIC_STAGES].rotate;
		end
	end

	assign out_valid = fin_v_s;
	assign out_data = fin_s;

endmodule

// ===== design/holonomic_drive_mixer.sv =====
// top level: stream ports, drive mode register, wheel mixing and output skid buffer
//
// The mixer takes one stick sample per clock while s_tready is high and returns
// the four X-drive wheel speeds through an entry stage, one vectoring cordic
// iteration per stage with the integer square root in its first eight stages, a
// heading and quarter-turn stage, one rotation cordic iteration per stage, a
// truncation stage and the output register. The pipeline moves whenever the skid
// register is empty, so input beats keep flowing while a result waits at the
// output; s_tready drops only once a second result is parked behind an unaccepted
// one. In disabled mode beats are accepted and produce no result. The user must
// write drive_mode through the cfg channel only while idle; it is not enforced.
module holonomic_drive_mixer import hdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,   // stick_x, stick_y, rotate_cmd, heading
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,   // wheel_a_speed, wheel_b_speed, wheel_c_speed, wheel_d_speed
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MODE_W-1:0] cfg_data   // drive_mode
);

	logic [MODE_W-1:0] mode_q;
	logic              out_v_q, skid_v_q;
	wheels_t           out_q, skid_q;

	logic                      en, enabled, fc;
	logic signed [STICK_W-1:0] stick_x, stick_y;
	side_t                     side;
	logic                      vec_v, fin_v;
	vec_out_t                  vec_data;
	rot_out_t                  fin_data;
	wheels_t                   mix;
	logic signed [WHEEL_W-1:0] r;

	assign en = !skid_v_q;
	assign s_tready = en;
	assign cfg_ready = 1'b1;
	assign enabled = (mode_q == MODE_FIELD) || (mode_q == MODE_ROBOT);
	assign fc = (mode_q == MODE_FIELD);

	assign stick_x = s_tdata[7:0];
	assign stick_y = s_tdata[15:8];
	assign side.rotate = s_tdata[23:16];
	assign side.heading = s_tdata[39:24];

	hdm_vectoring u_vec (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid && enabled),
		.in_x     (stick_x),
		.in_y     (stick_y),
		.in_side  (side),
		.out_valid(vec_v),
		.out_data (vec_data)
	);

	hdm_rotation u_rot (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.heading_en   (fc),
		.in_valid     (vec_v),
		.in_data      (vec_data),
		.out_valid    (fin_v),
		.out_data     (fin_data)
	);

	always_comb begin
		r = {{(WHEEL_W-STICK_W){fin_data.rotate[STICK_W-1]}}, fin_data.rotate};
		mix.a = fin_data.y + fin_data.x + r;
		mix.b = -fin_data.y + fin_data.x + r;
		mix.c = fin_data.y - fin_data.x + r;
		mix.d = -fin_data.y - fin_data.x + r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FIELD;
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (skid_v_q) begin
				if (m_tready) begin
					skid_v_q <= 1'b0;
				end
			end else if (fin_v) begin
				if (!out_v_q || m_tready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (fin_v) begin
			if (!out_v_q || m_tready) begin
				out_q <= mix;
			end else begin
				skid_q <= mix;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a beat while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && m_tready |=> !skid_v_q)
		else $error("skid beat not moved to output after a take");

	a_skid_catches: assert property (@(posedge clk) disable iff (!arst_n)
		fin_v && !skid_v_q && out_v_q && !m_tready |=> skid_v_q)
		else $error("finished beat not parked in skid during a stall");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_v_q && !fin_v && m_tready |=> !out_v_q)
		else $error("output valid without a finished beat");
`endif

endmodule
